// ===== rtl/rlep_pkg.sv =====
// Shared types, constants and helpers for the Life run-length pattern parser.
`timescale 1ns / 1ps

package rlep_pkg;

   // counter and field sizing
   localparam int COUNT_BITS  = 16;
   localparam int RULE_DIGITS = 9;
   localparam int DIM_BITS    = 16;
   localparam int ACC_BITS    = (COUNT_BITS > DIM_BITS) ? DIM_BITS : COUNT_BITS;
   localparam int VAL_BITS    = ACC_BITS + 4;
   localparam logic [VAL_BITS-1:0] COUNT_LIMIT = VAL_BITS'((64'd1 << ACC_BITS) - 64'd1);
   localparam logic [DIM_BITS-1:0] DEFAULT_DIM = DIM_BITS'(64);

   // header template
   localparam int HDR_LEN       = 28;
   localparam int HDR_STEP_BITS = 5;
   localparam int HDR_CHAIN     = 4;
   localparam logic [HDR_STEP_BITS-1:0] HDR_STEP_WIDTH  = HDR_STEP_BITS'(4);
   localparam logic [HDR_STEP_BITS-1:0] HDR_STEP_HEIGHT = HDR_STEP_BITS'(11);
   localparam logic [HDR_STEP_BITS-1:0] HDR_STEP_BIRTH  = HDR_STEP_BITS'(22);
   localparam logic [HDR_STEP_BITS-1:0] HDR_STEP_FIRST  = HDR_STEP_BITS'(1);
   localparam logic [7:0] HE_SPACE = 8'h01;
   localparam logic [7:0] HE_NUM   = 8'h02;

   // characters
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_BANG   = 8'h21;
   localparam logic [7:0] CH_HASH   = 8'h23;
   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_NL     = 8'h0A;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;
   localparam logic [7:0] CH_B      = 8'h62;
   localparam logic [7:0] CH_X      = 8'h78;

   // register file
   localparam int CSR_INDEX_BITS = 1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DEFAULT_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DEFAULT_HEIGHT = 1'b1;

   typedef enum logic [2:0] {
      PH_LINE,
      PH_COMMENT,
      PH_HEADER,
      PH_BODY,
      PH_DONE
   } phase_type;

   typedef enum logic [1:0] {
      KIND_RUN    = 2'd0,
      KIND_HEADER = 2'd1,
      KIND_END    = 2'd2,
      KIND_ERROR  = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      ERR_LINE_SPACE      = 3'd0,
      ERR_SECOND_HEADER   = 3'd1,
      ERR_HEADER_MISMATCH = 3'd2,
      ERR_EMPTY_SIZE      = 3'd3,
      ERR_RULE_NINE       = 3'd4,
      ERR_NEWLINE_COUNT   = 3'd5,
      ERR_OUTSIDE         = 3'd6,
      ERR_OVERFLOW        = 3'd7
   } err_type;

   // what one byte does to the header match
   typedef struct packed {
      logic [HDR_STEP_BITS-1:0] step;
      logic                     fail;
      err_type                  code;
      logic                     add_digit;
      logic                     set_rule;
      logic                     rule_survival;
      logic                     store_width;
      logic                     store_height;
      logic                     clear_num;
      logic                     done;
   } hdr_act_type;

   typedef struct packed {
      kind_type                kind;
      logic [DIM_BITS-1:0]     row;
      logic [DIM_BITS-1:0]     col;
      logic [DIM_BITS-1:0]     run_length;
      logic                    alive;
      logic [DIM_BITS-1:0]     pattern_width;
      logic [DIM_BITS-1:0]     pattern_height;
      logic [RULE_DIGITS-1:0]  birth_mask;
      logic [RULE_DIGITS-1:0]  survival_mask;
      err_type                 error_code;
   } result_type;

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= CH_ZERO) && (c <= CH_NINE);
   endfunction

   // header template: literal bytes, or HE_SPACE / HE_NUM markers
   function automatic logic [7:0] hdr_elem(input logic [HDR_STEP_BITS-1:0] s);
      logic [7:0] e;
      unique case (s)
         5'd0:    e = 8'h78;   // x
         5'd1:    e = HE_SPACE;
         5'd2:    e = 8'h3D;   // =
         5'd3:    e = HE_SPACE;
         5'd4:    e = HE_NUM;
         5'd5:    e = 8'h2C;   // ,
         5'd6:    e = HE_SPACE;
         5'd7:    e = 8'h79;   // y
         5'd8:    e = HE_SPACE;
         5'd9:    e = 8'h3D;
         5'd10:   e = HE_SPACE;
         5'd11:   e = HE_NUM;
         5'd12:   e = 8'h2C;
         5'd13:   e = HE_SPACE;
         5'd14:   e = 8'h72;   // rule
         5'd15:   e = 8'h75;
         5'd16:   e = 8'h6C;
         5'd17:   e = 8'h65;
         5'd18:   e = HE_SPACE;
         5'd19:   e = 8'h3D;
         5'd20:   e = HE_SPACE;
         5'd21:   e = 8'h42;   // B
         5'd22:   e = HE_NUM;
         5'd23:   e = 8'h2F;   // /
         5'd24:   e = 8'h53;   // S
         5'd25:   e = HE_NUM;
         5'd26:   e = HE_SPACE;
         5'd27:   e = CH_NL;
         default: e = 8'h00;
      endcase
      return e;
   endfunction

endpackage

// ===== rtl/life_rle_pattern_parser.sv =====
// Life run-length pattern parser top level: input word register, parser, result register.
//
// Usage:
//   req_* carries one pattern text byte per word (req_char_byte) plus req_new_file,
//   which restarts the parser on that byte. rsp_* carries at most one result word
//   per byte: a cell run, a header record, an end marker or an error.
//   csr_* writes the default field width (index 0) and height (index 1), used for
//   bound checks until a header arrives; write only while the parser is idle.
// Timing:
//   Each byte is taken into an input register, decoded from there and its result
//   (if any) loaded into the result register when that register is free or
//   draining. The parser state updates as each byte is decoded, so one byte per
//   cycle is sustained while rsp_stall stays low; bytes with no result pass too.
// Reset (synchronous) empties both registers, sets both defaults to 64 and clears
//   the parser. When rsp_stall is high the result word holds; the input register
//   still takes one more byte and then req_stall rises until the result leaves.
`timescale 1ns / 1ps

module life_rle_pattern_parser import rlep_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [7:0]                req_char_byte,
   input  logic                      req_new_file,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [1:0]                rsp_kind,
   output logic [DIM_BITS-1:0]       rsp_row,
   output logic [DIM_BITS-1:0]       rsp_col,
   output logic [DIM_BITS-1:0]       rsp_run_length,
   output logic                      rsp_alive,
   output logic [DIM_BITS-1:0]       rsp_pattern_width,
   output logic [DIM_BITS-1:0]       rsp_pattern_height,
   output logic [RULE_DIGITS-1:0]    rsp_birth_mask,
   output logic [RULE_DIGITS-1:0]    rsp_survival_mask,
   output logic [2:0]                rsp_error_code,
   input  logic                      csr_write_enable,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [DIM_BITS-1:0]       csr_write_data
);

   logic                in_valid_ff, in_valid_in;
   logic [7:0]          in_char_ff, in_char_in;
   logic                in_new_ff, in_new_in;
   logic                rsp_valid_ff, rsp_valid_in;
   result_type          res_ff, res_in;
   logic [DIM_BITS-1:0] dflt_w_ff, dflt_w_in;
   logic [DIM_BITS-1:0] dflt_h_ff, dflt_h_in;

   logic       advance;
   logic       take_in;
   logic       emit;
   result_type result;

   // the decode stage moves whenever it holds a byte and the result register is free or draining
   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign take_in   = req_valid && !req_stall;

   always_comb begin
      in_char_in = take_in ? req_char_byte : in_char_ff;
      in_new_in  = take_in ? req_new_file : in_new_ff;
      priority if (take_in) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   rlep_parser u_parser (
      .clock          (clock),
      .reset          (reset),
      .step_en        (advance),
      .char_byte      (in_char_ff),
      .new_file       (in_new_ff),
      .default_width  (dflt_w_ff),
      .default_height (dflt_h_ff),
      .emit           (emit),
      .result         (result)
   );

   always_comb begin
      res_in = (advance && emit) ? result : res_ff;
      priority if (advance) begin
         rsp_valid_in = emit;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_comb begin
      dflt_w_in = dflt_w_ff;
      dflt_h_in = dflt_h_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_DEFAULT_WIDTH:  dflt_w_in = csr_write_data;
            CSR_DEFAULT_HEIGHT: dflt_h_in = csr_write_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         dflt_w_ff    <= DEFAULT_DIM;
         dflt_h_ff    <= DEFAULT_DIM;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         dflt_w_ff    <= dflt_w_in;
         dflt_h_ff    <= dflt_h_in;
      end
   end

   always_ff @(posedge clock) begin
      in_char_ff <= in_char_in;
      in_new_ff  <= in_new_in;
      res_ff     <= res_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_kind           = res_ff.kind;
   assign rsp_row            = res_ff.row;
   assign rsp_col            = res_ff.col;
   assign rsp_run_length     = res_ff.run_length;
   assign rsp_alive          = res_ff.alive;
   assign rsp_pattern_width  = res_ff.pattern_width;
   assign rsp_pattern_height = res_ff.pattern_height;
   assign rsp_birth_mask     = res_ff.birth_mask;
   assign rsp_survival_mask  = res_ff.survival_mask;
   assign rsp_error_code     = res_ff.error_code;

endmodule

// ===== rtl/rlep_header.sv =====
// Header template matcher: advances over optional spaces and numbers for one byte.
`timescale 1ns / 1ps

module rlep_header import rlep_pkg::*; (
   input  logic [HDR_STEP_BITS-1:0] step,
   input  logic [7:0]               char_byte,
   input  logic                     num_present,
   input  logic                     digit_ovf,
   output hdr_act_type              act
);

   logic [HDR_STEP_BITS-1:0] s;
   logic                     stop;
   logic [7:0]               e;
   logic                     dig;
   logic [3:0]               dval;

   assign dig  = is_digit(char_byte);
   assign dval = char_byte[3:0];

   // at most space, number, space, literal in one byte
   always_comb begin
      act  = '0;
      s    = step;
      stop = 1'b0;
      e    = '0;
      for (int k = 0; k < HDR_CHAIN; k++) begin
         if (!stop) begin
            e = hdr_elem(s);
            if (s >= HDR_STEP_BITS'(HDR_LEN)) begin
               act.fail = 1'b1;
               act.code = ERR_HEADER_MISMATCH;
               stop     = 1'b1;
            end else if (e == HE_SPACE) begin
               if (char_byte == CH_SPACE) begin
                  stop = 1'b1;
               end else begin
                  s = s + HDR_STEP_BITS'(1);
               end
            end else if (e == HE_NUM) begin
               if (dig) begin
                  if (s > HDR_STEP_HEIGHT) begin
                     if (dval >= 4'(RULE_DIGITS)) begin
                        act.fail = 1'b1;
                        act.code = ERR_RULE_NINE;
                     end else begin
                        act.set_rule      = 1'b1;
                        act.rule_survival = (s != HDR_STEP_BIRTH);
                     end
                  end else if (digit_ovf) begin
                     act.fail = 1'b1;
                     act.code = ERR_OVERFLOW;
                  end else begin
                     act.add_digit = 1'b1;
                  end
                  stop = 1'b1;
               end else begin
                  if (s <= HDR_STEP_HEIGHT) begin
                     if (!num_present) begin
                        act.fail = 1'b1;
                        act.code = ERR_EMPTY_SIZE;
                        stop     = 1'b1;
                     end else if (s == HDR_STEP_WIDTH) begin
                        act.store_width = 1'b1;
                     end else begin
                        act.store_height = 1'b1;
                     end
                  end
                  if (!stop) begin
                     act.clear_num = 1'b1;
                     s             = s + HDR_STEP_BITS'(1);
                  end
               end
            end else begin
               if (char_byte != e) begin
                  act.fail = 1'b1;
                  act.code = ERR_HEADER_MISMATCH;
               end else begin
                  s = s + HDR_STEP_BITS'(1);
                  if (s == HDR_STEP_BITS'(HDR_LEN)) begin
                     act.done = 1'b1;
                  end
               end
               stop = 1'b1;
            end
         end
      end
      if (!stop) begin
         act.fail = 1'b1;
         act.code = ERR_HEADER_MISMATCH;
      end
      act.step = s;
   end

endmodule

// ===== rtl/rlep_parser.sv =====
// Parser state and per-byte decode: cursors, count accumulator, header fields.
`timescale 1ns / 1ps

module rlep_parser import rlep_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                step_en,
   input  logic [7:0]          char_byte,
   input  logic                new_file,
   input  logic [DIM_BITS-1:0] default_width,
   input  logic [DIM_BITS-1:0] default_height,
   output logic                emit,
   output result_type          result
);

   phase_type                phase_ff, phase_in, cur_phase;
   logic [HDR_STEP_BITS-1:0] step_ff, step_in, cur_step;
   logic [ACC_BITS-1:0]      acc_ff, acc_in, cur_acc;
   logic                     present_ff, present_in, cur_present;
   logic                     after_ff, after_in, cur_after;
   logic [DIM_BITS-1:0]      col_ff, col_in, cur_col;
   logic [DIM_BITS-1:0]      row_ff, row_in, cur_row;
   logic                     seen_ff, seen_in, cur_seen;
   logic [DIM_BITS-1:0]      held_w_ff, held_w_in, cur_held_w;
   logic [DIM_BITS-1:0]      held_h_ff, held_h_in, cur_held_h;
   logic [RULE_DIGITS-1:0]   held_b_ff, held_b_in, cur_held_b;
   logic [RULE_DIGITS-1:0]   held_s_ff, held_s_in, cur_held_s;

   logic [VAL_BITS-1:0]      val;
   logic                     ovf;
   logic                     dig;
   logic [DIM_BITS-1:0]      n16;
   logic [DIM_BITS:0]        row_sum, col_sum;
   logic [DIM_BITS-1:0]      bound_w, bound_h;
   logic [RULE_DIGITS-1:0]   rule_bit;
   hdr_act_type              hact;

   // decode events
   logic    ev_fail;
   err_type ev_code;
   logic    ev_comment, ev_header, ev_body, ev_line, ev_end, ev_hdr, ev_run, body;

   // new_file wipes state before the byte is used
   always_comb begin
      if (new_file) begin
         cur_phase   = PH_LINE;
         cur_step    = '0;
         cur_acc     = '0;
         cur_present = 1'b0;
         cur_after   = 1'b0;
         cur_col     = '0;
         cur_row     = '0;
         cur_seen    = 1'b0;
         cur_held_w  = '0;
         cur_held_h  = '0;
         cur_held_b  = '0;
         cur_held_s  = '0;
      end else begin
         cur_phase   = phase_ff;
         cur_step    = step_ff;
         cur_acc     = acc_ff;
         cur_present = present_ff;
         cur_after   = after_ff;
         cur_col     = col_ff;
         cur_row     = row_ff;
         cur_seen    = seen_ff;
         cur_held_w  = held_w_ff;
         cur_held_h  = held_h_ff;
         cur_held_b  = held_b_ff;
         cur_held_s  = held_s_ff;
      end
   end

   assign dig      = is_digit(char_byte);
   assign val      = VAL_BITS'(cur_acc) * VAL_BITS'(10) + VAL_BITS'(char_byte[3:0]);
   assign ovf      = val > COUNT_LIMIT;
   assign n16      = cur_present ? DIM_BITS'(cur_acc) : DIM_BITS'(1);
   assign row_sum  = {1'b0, cur_row} + {1'b0, n16};
   assign col_sum  = {1'b0, cur_col} + {1'b0, n16};
   // before a header the bounds track the configured defaults
   assign bound_w  = cur_seen ? cur_held_w : default_width;
   assign bound_h  = cur_seen ? cur_held_h : default_height;
   assign rule_bit = RULE_DIGITS'(1) << char_byte[3:0];

   rlep_header u_header (
      .step        (cur_step),
      .char_byte   (char_byte),
      .num_present (cur_present),
      .digit_ovf   (ovf),
      .act         (hact)
   );

   // per-byte decode: events and datapath next values
   always_comb begin
      ev_fail    = 1'b0;
      ev_code    = ERR_LINE_SPACE;
      ev_comment = 1'b0;
      ev_header  = 1'b0;
      ev_body    = 1'b0;
      ev_line    = 1'b0;
      ev_end     = 1'b0;
      ev_hdr     = 1'b0;
      ev_run     = 1'b0;
      body       = 1'b0;
      step_in    = cur_step;
      acc_in     = cur_acc;
      present_in = cur_present;
      after_in   = cur_after;
      col_in     = cur_col;
      row_in     = cur_row;
      seen_in    = cur_seen;
      held_w_in  = cur_held_w;
      held_h_in  = cur_held_h;
      held_b_in  = cur_held_b;
      held_s_in  = cur_held_s;

      unique case (cur_phase)
         PH_LINE: begin
            priority if (char_byte == CH_SPACE) begin
               ev_fail = 1'b1;
               ev_code = ERR_LINE_SPACE;
            end else if (char_byte == CH_HASH) begin
               ev_comment = 1'b1;
            end else if (char_byte == CH_X) begin
               if (cur_seen) begin
                  ev_fail = 1'b1;
                  ev_code = ERR_SECOND_HEADER;
               end else begin
                  // the 'x' itself matches the first template byte
                  ev_header  = 1'b1;
                  step_in    = HDR_STEP_FIRST;
                  acc_in     = '0;
                  present_in = 1'b0;
                  held_b_in  = '0;
                  held_s_in  = '0;
               end
            end else begin
               body = 1'b1;
            end
         end
         PH_COMMENT: begin
            if (char_byte == CH_NL) begin
               ev_line = 1'b1;
            end
         end
         PH_HEADER: begin
            step_in = hact.step;
            if (hact.fail) begin
               ev_fail = 1'b1;
               ev_code = hact.code;
            end else begin
               if (hact.add_digit) begin
                  acc_in     = val[ACC_BITS-1:0];
                  present_in = 1'b1;
               end
               if (hact.set_rule) begin
                  if (hact.rule_survival) begin
                     held_s_in = cur_held_s | rule_bit;
                  end else begin
                     held_b_in = cur_held_b | rule_bit;
                  end
               end
               if (hact.store_width) begin
                  held_w_in = DIM_BITS'(cur_acc);
               end
               if (hact.store_height) begin
                  held_h_in = DIM_BITS'(cur_acc);
               end
               if (hact.clear_num) begin
                  acc_in     = '0;
                  present_in = 1'b0;
               end
               if (hact.done) begin
                  seen_in = 1'b1;
                  ev_line = 1'b1;
                  ev_hdr  = 1'b1;
               end
            end
         end
         PH_BODY: begin
            body = 1'b1;
         end
         PH_DONE: begin
         end
         default: begin
         end
      endcase

      if (body) begin
         ev_body = 1'b1;
         priority if (!cur_after && dig) begin
            if (ovf) begin
               ev_fail = 1'b1;
               ev_code = ERR_OVERFLOW;
            end else begin
               acc_in     = val[ACC_BITS-1:0];
               present_in = 1'b1;
            end
         end else if (char_byte == CH_SPACE) begin
            after_in = 1'b1;
         end else begin
            acc_in     = '0;
            present_in = 1'b0;
            after_in   = 1'b0;
            priority if (char_byte == CH_DOLLAR) begin
               col_in = '0;
               row_in = row_sum[DIM_BITS] ? '1 : row_sum[DIM_BITS-1:0];
            end else if (char_byte == CH_NL) begin
               if (cur_present) begin
                  ev_fail = 1'b1;
                  ev_code = ERR_NEWLINE_COUNT;
               end else begin
                  ev_line = 1'b1;
               end
            end else if (char_byte == CH_BANG) begin
               ev_end = 1'b1;
            end else if (n16 == '0) begin
               // zero count: nothing drawn
            end else if ((cur_row >= bound_h) || (col_sum > {1'b0, bound_w})) begin
               ev_fail = 1'b1;
               ev_code = ERR_OUTSIDE;
            end else begin
               ev_run = 1'b1;
               col_in = col_sum[DIM_BITS-1:0];
            end
         end
      end
   end

   // next phase
   always_comb begin
      priority if (ev_fail || ev_end) begin
         phase_in = PH_DONE;
      end else if (ev_line) begin
         phase_in = PH_LINE;
      end else if (ev_comment) begin
         phase_in = PH_COMMENT;
      end else if (ev_header) begin
         phase_in = PH_HEADER;
      end else if (ev_body) begin
         phase_in = PH_BODY;
      end else begin
         phase_in = cur_phase;
      end
   end

   // result word
   always_comb begin
      result = '0;
      emit   = ev_fail || ev_end || ev_hdr || ev_run;
      priority if (ev_fail) begin
         result.kind       = KIND_ERROR;
         result.error_code = ev_code;
      end else if (ev_end) begin
         result.kind = KIND_END;
      end else if (ev_hdr) begin
         result.kind           = KIND_HEADER;
         result.pattern_width  = cur_held_w;
         result.pattern_height = cur_held_h;
         result.birth_mask     = cur_held_b;
         result.survival_mask  = cur_held_s;
      end else if (ev_run) begin
         result.kind       = KIND_RUN;
         result.row        = cur_row;
         result.col        = cur_col;
         result.run_length = n16;
         result.alive      = (char_byte != CH_B);
      end else begin
         result.kind = KIND_RUN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_LINE;
         step_ff    <= '0;
         acc_ff     <= '0;
         present_ff <= 1'b0;
         after_ff   <= 1'b0;
         col_ff     <= '0;
         row_ff     <= '0;
         seen_ff    <= 1'b0;
         held_w_ff  <= '0;
         held_h_ff  <= '0;
         held_b_ff  <= '0;
         held_s_ff  <= '0;
      end else if (step_en) begin
         phase_ff   <= phase_in;
         step_ff    <= step_in;
         acc_ff     <= acc_in;
         present_ff <= present_in;
         after_ff   <= after_in;
         col_ff     <= col_in;
         row_ff     <= row_in;
         seen_ff    <= seen_in;
         held_w_ff  <= held_w_in;
         held_h_ff  <= held_h_in;
         held_b_ff  <= held_b_in;
         held_s_ff  <= held_s_in;
      end
   end

endmodule
